[rtl/interval_flank_generator_unit_assert.svh]
// ----------------------------------------------------------------------------
// Interval flank generator assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_FLANK_GENERATOR_UNIT_ASSERT_SVH
`define INTERVAL_FLANK_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IFG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ifg assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define IFG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ifg assertion failed: next-cycle check");

`endif

[rtl/ifg_pkg.sv]
// ----------------------------------------------------------------------------
// Interval flank generator package
// Widths, constants and shared types of the flank generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ifg_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int AMOUNT_W   = 48;
   localparam int COORD_W    = 31;
   localparam int ROW_W      = 32;
   localparam int HALF_W     = AMOUNT_W / 2;
   localparam int PROD_W     = COORD_W + HALF_W;
   localparam int FULL_W     = PROD_W + HALF_W;
   localparam int MAG_W      = 41;
   localparam int OFF_W      = MAG_W + 1;
   localparam int POS_W      = OFF_W + 1;
   localparam int INDEX_W    = 3;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 96;

   // Offset magnitude saturates at 2^40 bases.
   localparam logic [MAG_W-1:0]   OFF_CAP   = 41'h100_0000_0000;
   localparam logic [COORD_W-1:0] COORD_MAX = 31'h7FFF_FFFF;

   typedef enum logic [INDEX_W-1:0] {
      REG_LEFT_AMOUNT   = 3'd0,
      REG_RIGHT_AMOUNT  = 3'd1,
      REG_FRACTION_MODE = 3'd2,
      REG_STRAND_MODE   = 3'd3,
      REG_TRIM_MODE     = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [AMOUNT_W-1:0] left_amount;
      logic [AMOUNT_W-1:0] right_amount;
      logic                fraction_mode;
      logic                strand_mode;
      logic                trim_mode;
   } cfg_type;

   // One interval with its signed flank offsets, handed to the flank stage.
   typedef struct packed {
      logic [COORD_W-1:0]      interval_start;
      logic [COORD_W-1:0]      interval_end;
      logic                    minus_strand;
      logic [COORD_W-1:0]      chrom_size;
      logic [ROW_W-1:0]        row_id;
      logic signed [OFF_W-1:0] left_off;
      logic signed [OFF_W-1:0] right_off;
   } off_item_type;

endpackage

`default_nettype wire

[rtl/ifg_csr.sv]
// ----------------------------------------------------------------------------
// Interval flank generator configuration registers
// Holds the flank amounts and mode bits written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ifg_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [ifg_pkg::INDEX_W-1:0]  csr_index,
   input  wire logic [ifg_pkg::AMOUNT_W-1:0] csr_wdata,
   output ifg_pkg::cfg_type                  cfg
);
   import ifg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_LEFT_AMOUNT:   cfg_in.left_amount   = csr_wdata;
            REG_RIGHT_AMOUNT:  cfg_in.right_amount  = csr_wdata;
            REG_FRACTION_MODE: cfg_in.fraction_mode = csr_wdata[0];
            REG_STRAND_MODE:   cfg_in.strand_mode   = csr_wdata[0];
            REG_TRIM_MODE:     cfg_in.trim_mode     = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/ifg_offset.sv]
// ----------------------------------------------------------------------------
// Interval flank generator offset pipeline
// Registers the interval, forms the scaled flank sizes in split partial
// products and reduces them to signed, saturated offsets in whole bases.
// ----------------------------------------------------------------------------
`default_nettype none

module ifg_offset #(
   parameter int FRAC_BITS = ifg_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  ifg_pkg::cfg_type                    cfg,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [ifg_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           take,
   output logic                                item_valid,
   output ifg_pkg::off_item_type               item
);
   import ifg_pkg::*;

   // Stage one: interval as received.
   logic                v1_ff, v1_in;
   logic [COORD_W-1:0]  start1_ff, end1_ff, chrom1_ff;
   logic                minus1_ff;
   logic [ROW_W-1:0]    row1_ff;

   // Stage two: partial products.
   logic                v2_ff, v2_in;
   logic [COORD_W-1:0]  start2_ff, end2_ff, chrom2_ff;
   logic                minus2_ff;
   logic [ROW_W-1:0]    row2_ff;
   logic                neg2_ff, neg2_in;
   logic [PROD_W-1:0]   plo_l_ff, phi_l_ff, plo_r_ff, phi_r_ff;
   logic [PROD_W-1:0]   plo_l_in, phi_l_in, plo_r_in, phi_r_in;

   // Stage three: offsets.
   logic                v3_ff, v3_in;
   off_item_type        item3_ff, item3_in;

   logic adv1, adv2, adv3;
   logic [COORD_W:0]    len;
   logic [COORD_W:0]    len_abs;
   logic [COORD_W-1:0]  mult_n;

   // Floor of the full product over 2^FRAC_BITS, capped, with the sign applied.
   function automatic logic signed [OFF_W-1:0] reduce_off(
      input logic [PROD_W-1:0] phi,
      input logic [PROD_W-1:0] plo,
      input logic              neg
   );
      logic [FULL_W-1:0] full;
      logic [FULL_W-1:0] q;
      logic [MAG_W-1:0]  mag;
      logic [OFF_W-1:0]  m;
      full = {phi, HALF_W'(0)} + FULL_W'(plo);
      q    = full >> FRAC_BITS;
      mag  = (q > FULL_W'(OFF_CAP)) ? OFF_CAP : q[MAG_W-1:0];
      m    = {1'b0, mag};
      return neg ? $signed(~m + 1'b1) : $signed(m);
   endfunction

   assign adv3       = take || !v3_ff;
   assign adv2       = adv3 || !v2_ff;
   assign adv1       = adv2 || !v1_ff;
   assign req_tready = adv1;

   assign v1_in = adv1 ? req_tvalid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   // In absolute mode the multiplier sees a length of one, which leaves the
   // integer part of the amount.
   always_comb begin
      len     = {1'b0, end1_ff} - {1'b0, start1_ff};
      len_abs = len[COORD_W] ? (~len + 1'b1) : len;
      if (cfg.fraction_mode) begin
         mult_n  = len_abs[COORD_W-1:0];
         neg2_in = len[COORD_W];
      end else begin
         mult_n  = COORD_W'(1);
         neg2_in = 1'b0;
      end
      plo_l_in = PROD_W'(mult_n) * PROD_W'(cfg.left_amount[HALF_W-1:0]);
      phi_l_in = PROD_W'(mult_n) * PROD_W'(cfg.left_amount[AMOUNT_W-1:HALF_W]);
      plo_r_in = PROD_W'(mult_n) * PROD_W'(cfg.right_amount[HALF_W-1:0]);
      phi_r_in = PROD_W'(mult_n) * PROD_W'(cfg.right_amount[AMOUNT_W-1:HALF_W]);
   end

   always_comb begin
      item3_in.interval_start = start2_ff;
      item3_in.interval_end   = end2_ff;
      item3_in.minus_strand   = minus2_ff;
      item3_in.chrom_size     = chrom2_ff;
      item3_in.row_id         = row2_ff;
      item3_in.left_off       = reduce_off(phi_l_ff, plo_l_ff, neg2_ff);
      item3_in.right_off      = reduce_off(phi_r_ff, plo_r_ff, neg2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         start1_ff <= req_tdata[30:0];
         end1_ff   <= req_tdata[61:31];
         minus1_ff <= req_tdata[62];
         chrom1_ff <= req_tdata[93:63];
         row1_ff   <= req_tdata[125:94];
      end
      if (adv2) begin
         start2_ff <= start1_ff;
         end2_ff   <= end1_ff;
         minus2_ff <= minus1_ff;
         chrom2_ff <= chrom1_ff;
         row2_ff   <= row1_ff;
         neg2_ff   <= neg2_in;
         plo_l_ff  <= plo_l_in;
         phi_l_ff  <= phi_l_in;
         plo_r_ff  <= plo_r_in;
         phi_r_ff  <= phi_r_in;
      end
      if (adv3) begin
         item3_ff <= item3_in;
      end
   end

   assign item_valid = v3_ff;
   assign item       = item3_ff;

endmodule

`default_nettype wire

[rtl/ifg_flank.sv]
// ----------------------------------------------------------------------------
// Interval flank generator flank stage
// Places both flanks, applies the keep and trim rules, and holds the pair in
// the result register, which hands out the kept flanks one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ifg_flank (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  ifg_pkg::cfg_type                    cfg,
   input  wire logic                           item_valid,
   input  ifg_pkg::off_item_type               item,
   output logic                                take,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [ifg_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import ifg_pkg::*;

   typedef struct packed {
      logic               keep;
      logic [COORD_W-1:0] fstart;
      logic [COORD_W-1:0] fend;
   } flank_type;

   logic               keep_l_ff, keep_l_in;
   logic               keep_r_ff, keep_r_in;
   logic [COORD_W-1:0] start_l_ff, end_l_ff, start_r_ff, end_r_ff;
   logic [ROW_W-1:0]   row_ff;

   logic signed [POS_W-1:0] st, en, lo, ro;
   logic signed [POS_W-1:0] ls, le, rs, re;
   logic                    swap;
   flank_type               left_new, right_new;
   logic                    xfer;

   // Keep rule, trim rule and output saturation for one flank.
   function automatic flank_type judge(
      input logic signed [POS_W-1:0] fs,
      input logic signed [POS_W-1:0] fe,
      input logic [COORD_W-1:0]      cs,
      input logic                    amount_nz,
      input logic                    trim
   );
      flank_type               r;
      logic signed [POS_W-1:0] cs_ext;
      logic                    in_range;
      cs_ext   = $signed({{(POS_W - COORD_W){1'b0}}, cs});
      in_range = (fs > 0) && (fe <= cs_ext);
      r.keep   = in_range ? amount_nz : trim;
      if (fs < 1) begin
         r.fstart = COORD_W'(1);
      end else if (fs > $signed(POS_W'(COORD_MAX))) begin
         r.fstart = COORD_MAX;
      end else begin
         r.fstart = fs[COORD_W-1:0];
      end
      // The chromosome size never exceeds the largest coordinate.
      if (fe > cs_ext) begin
         r.fend = cs;
      end else if (fe < 0) begin
         r.fend = '0;
      end else begin
         r.fend = fe[COORD_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      st   = $signed({{(POS_W - COORD_W){1'b0}}, item.interval_start});
      en   = $signed({{(POS_W - COORD_W){1'b0}}, item.interval_end});
      lo   = POS_W'(item.left_off);
      ro   = POS_W'(item.right_off);
      swap = cfg.strand_mode && item.minus_strand;
      if (swap) begin
         ls = en;
         le = en + lo;
         rs = st - ro;
         re = st;
      end else begin
         ls = st - lo;
         le = st;
         rs = en;
         re = en + ro;
      end
      left_new  = judge(ls, le, item.chrom_size, |cfg.left_amount, cfg.trim_mode);
      right_new = judge(rs, re, item.chrom_size, |cfg.right_amount, cfg.trim_mode);
   end

   assign rsp_tvalid = keep_l_ff || keep_r_ff;
   assign rsp_tlast  = !(keep_l_ff && keep_r_ff);
   assign rsp_tuser  = !keep_l_ff;
   assign xfer       = rsp_tvalid && rsp_tready;
   // A new pair enters once the last kept flank of the held pair leaves.
   assign take       = !rsp_tvalid || (xfer && rsp_tlast);

   always_comb begin
      if (keep_l_ff) begin
         rsp_tdata = {2'b00, row_ff, end_l_ff, start_l_ff};
      end else begin
         rsp_tdata = {2'b00, row_ff, end_r_ff, start_r_ff};
      end
   end

   always_comb begin
      keep_l_in = keep_l_ff;
      keep_r_in = keep_r_ff;
      if (take) begin
         keep_l_in = item_valid && left_new.keep;
         keep_r_in = item_valid && right_new.keep;
      end else if (xfer) begin
         keep_l_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_l_ff <= 1'b0;
         keep_r_ff <= 1'b0;
      end else begin
         keep_l_ff <= keep_l_in;
         keep_r_ff <= keep_r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         start_l_ff <= left_new.fstart;
         end_l_ff   <= left_new.fend;
         start_r_ff <= right_new.fstart;
         end_r_ff   <= right_new.fend;
         row_ff     <= item.row_id;
      end
   end

endmodule

`default_nettype wire

[rtl/interval_flank_generator_unit.sv]
// ----------------------------------------------------------------------------
// Interval flank generator
// Turns one genomic interval into its left and right flank intervals.
//
//   channel  direction  transfer carries
//   req      in         one interval: start, end, strand, chromosome size, row
//   rsp      out        one flank: start, end, row; side in tuser; tlast
//   csr      in         register write: index and data, no read-back
//
// An interval passes the interval, partial-product and offset registers to
// the result register. Unless the result port stalls, an interval is
// accepted every cycle while each yields at most one flank; one yielding
// two holds the pipe until both leave; the port moves one flank per transfer.
// Reset clears the registers and the pipe; there is no clearing pass.
// A stalled result holds the pipe behind it; idle slots are filled in.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_flank_generator_unit #(
   parameter int FRAC_BITS = ifg_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // csr write port
   input  wire logic                           csr_we,
   input  wire logic [ifg_pkg::INDEX_W-1:0]    csr_index,
   input  wire logic [ifg_pkg::AMOUNT_W-1:0]   csr_wdata,
   // interval input
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // interval_start, interval_end, minus_strand, chrom_size, row_id, zero pad
   input  wire logic [ifg_pkg::REQ_DATA_W-1:0] req_tdata,
   // flank output
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // flank_start, flank_end, source_row, zero pad
   output logic [ifg_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // flank_side
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import ifg_pkg::*;

   cfg_type      cfg;
   off_item_type item;
   logic         item_valid;
   logic         take;

   ifg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ifg_offset #(
      .FRAC_BITS (FRAC_BITS)
   ) u_offset (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   ifg_flank u_flank (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[rtl/ifg_checker.sv]
// ----------------------------------------------------------------------------
// Interval flank generator port checker
// Watches the result port for pairing, ordering and range rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "interval_flank_generator_unit_assert.svh"

module ifg_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [ifg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                           rsp_tuser,
   input wire logic                           rsp_tlast
);
   import ifg_pkg::*;

   logic rsp_xfer;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // A stalled flank stays offered unchanged.
   `IFG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // A right flank always closes its interval.
   `IFG_ASSERT_IMP(a_right_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)

   // A left flank that is not last is followed at once by the right flank of the same row.
   `IFG_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_xfer && !rsp_tlast, rsp_tvalid && rsp_tuser && (rsp_tdata[93:62] == $past(rsp_tdata[93:62])))

   // Flank starts are saturated to at least one.
   `IFG_ASSERT_IMP(a_start_nonzero, clock, reset, rsp_tvalid, rsp_tdata[30:0] != 31'd0)

   // The pad bits above the row are zero with a flank offered and req valid or not ready.
   `IFG_ASSERT_IMP(a_pad_zero, clock, reset, rsp_tvalid && (req_tvalid || !req_tready), rsp_tdata[95:94] == 2'b00)

endmodule

bind interval_flank_generator_unit ifg_checker u_checker (.*);

`default_nettype wire
